[rtl/core/sfr_pkg.sv]
package sfr_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 1024;
    localparam int unsigned QUEUE_SLOTS_DEF = 8;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACK,
        ST_SRC,
        ST_DST,
        ST_SYSID,
        ST_TYPE,
        ST_SER_HI,
        ST_SER_LO,
        ST_SIZE_HI,
        ST_SIZE_LO,
        ST_STX,
        ST_PAYLOAD,
        ST_ETX,
        ST_CSUM,
        ST_EOT
    } t_parse_state;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_DONE    = 3'd2,
        EV_NAK     = 3'd3,
        EV_PASS    = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SIZE     = 3'd1,
        ERR_NO_STX   = 3'd2,
        ERR_NO_ETX   = 3'd3,
        ERR_CHECKSUM = 3'd4,
        ERR_NO_EOT   = 3'd5
    } t_error;

endpackage

[rtl/core/serial_frame_receiver_core.sv]
// Serial frame receiver: one received byte per request, one result per byte.
// Latency: the result is valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless i_ready low holds a pending result; the parser state,
// checksum and counter update in a single pass between the input handshake and the result register.
// Reset (i_rst_n low, synchronous): parser idle, header fields, checksum,
// payload count and slot index cleared, passthrough off, no result pending.
module serial_frame_receiver_core #(
    parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF,
    parameter int unsigned QUEUE_SLOTS = sfr_pkg::QUEUE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_overrun,

    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [9:0]  o_byte_index,
    output logic [7:0]  o_expect_ack,
    output logic [7:0]  o_src_addr,
    output logic [7:0]  o_dst_addr,
    output logic [7:0]  o_system_id,
    output logic [7:0]  o_msg_type,
    output logic [15:0] o_serial_number,
    output logic [15:0] o_msg_size,
    output logic [2:0]  o_error_code,
    output logic [2:0]  o_slot
);
    import sfr_pkg::*;

    localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned SW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

    logic          r_passthrough;
    t_parse_state  r_state, n_state;
    logic [7:0]    r_xor, n_xor;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_ack, n_ack, r_src, n_src, r_dst, n_dst;
    logic [7:0]    r_sysid, n_sysid, r_type, n_type;
    logic [15:0]   r_serial, n_serial, r_size, n_size;
    logic [SW-1:0] r_slot_idx, n_slot_idx;

    logic          r_out_valid;
    t_event        r_event, n_event;
    t_error        r_error, n_error;
    logic [7:0]    r_data, n_data;
    logic [9:0]    r_index, n_index;
    logic [2:0]    r_slot_out;

    logic          accept;
    logic [15:0]   size_full;
    logic [16:0]   count_inc;
    logic [16:0]   count_ext;
    logic [SW:0]   slot_inc;
    logic [8:0]    slot_ext;

    assign o_ready   = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign size_full = {r_size[15:8], i_rx_byte};
    assign count_ext = 17'(r_count);
    assign count_inc = count_ext + 17'd1;
    assign slot_inc  = (SW + 1)'(r_slot_idx) + (SW + 1)'(1);
    assign slot_ext  = 9'(r_slot_idx);

    // next parser state
    always_comb begin
        n_state = r_state;
        if (i_overrun) begin
            n_state = ST_IDLE;
        end else begin
            unique case (r_state)
                ST_ACK:     n_state = ST_SRC;
                ST_SRC:     n_state = ST_DST;
                ST_DST:     n_state = ST_SYSID;
                ST_SYSID:   n_state = ST_TYPE;
                ST_TYPE:    n_state = ST_SER_HI;
                ST_SER_HI:  n_state = ST_SER_LO;
                ST_SER_LO:  n_state = ST_SIZE_HI;
                ST_SIZE_HI: n_state = ST_SIZE_LO;
                ST_SIZE_LO: n_state = (size_full > 16'(MAX_PAYLOAD)) ? ST_IDLE : ST_STX;
                ST_STX: begin
                    if (i_rx_byte != CH_STX)  n_state = ST_IDLE;
                    else if (r_size == 16'd0) n_state = ST_ETX;
                    else                      n_state = ST_PAYLOAD;
                end
                ST_PAYLOAD: begin
                    if (count_inc >= 17'(r_size)) n_state = ST_ETX;
                end
                ST_ETX:     n_state = (i_rx_byte == CH_ETX) ? ST_CSUM : ST_IDLE;
                ST_CSUM:    n_state = (i_rx_byte == r_xor) ? ST_EOT : ST_IDLE;
                ST_EOT:     n_state = ST_IDLE;
                default:    n_state = (i_rx_byte == CH_SOH) ? ST_ACK : ST_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_xor      = r_xor;
        n_count    = r_count;
        n_ack      = r_ack;
        n_src      = r_src;
        n_dst      = r_dst;
        n_sysid    = r_sysid;
        n_type     = r_type;
        n_serial   = r_serial;
        n_size     = r_size;
        n_slot_idx = r_slot_idx;
        n_event    = EV_NONE;
        n_error    = ERR_NONE;
        n_data     = 8'd0;
        n_index    = 10'd0;
        if (!i_overrun) begin
            unique case (r_state)
                ST_ACK: begin
                    n_ack = i_rx_byte;
                    n_xor = i_rx_byte;
                end
                ST_SRC: begin
                    n_src = i_rx_byte;
                    n_xor = r_xor ^ i_rx_byte;
                end
                ST_DST: begin
                    n_dst = i_rx_byte;
                    n_xor = r_xor ^ i_rx_byte;
                end
                ST_SYSID: begin
                    n_sysid = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                end
                ST_TYPE: begin
                    n_type = i_rx_byte;
                    n_xor  = r_xor ^ i_rx_byte;
                end
                ST_SER_HI: begin
                    n_serial = {i_rx_byte, 8'd0};
                    n_xor    = r_xor ^ i_rx_byte;
                end
                ST_SER_LO: begin
                    n_serial = {r_serial[15:8], i_rx_byte};
                    n_xor    = r_xor ^ i_rx_byte;
                end
                ST_SIZE_HI: n_size = {i_rx_byte, 8'd0};
                ST_SIZE_LO: begin
                    n_size = size_full;
                    if (size_full > 16'(MAX_PAYLOAD)) begin
                        n_event = EV_NAK;
                        n_error = ERR_SIZE;
                    end
                end
                ST_STX: begin
                    if (i_rx_byte == CH_STX) begin
                        n_count = '0;
                    end else begin
                        n_event = EV_NAK;
                        n_error = ERR_NO_STX;
                    end
                end
                ST_PAYLOAD: begin
                    n_event = EV_PAYLOAD;
                    n_data  = i_rx_byte;
                    n_index = count_ext[9:0];
                    n_xor   = r_xor ^ i_rx_byte;
                    n_count = count_inc[CW-1:0];
                end
                ST_ETX: begin
                    if (i_rx_byte != CH_ETX) begin
                        n_event = EV_NAK;
                        n_error = ERR_NO_ETX;
                    end
                end
                ST_CSUM: begin
                    if (i_rx_byte != r_xor) begin
                        n_event = EV_NAK;
                        n_error = ERR_CHECKSUM;
                    end
                end
                ST_EOT: begin
                    if (i_rx_byte == CH_EOT) begin
                        n_event    = EV_DONE;
                        n_slot_idx = (slot_inc >= (SW + 1)'(QUEUE_SLOTS)) ?
                                     '0 : slot_inc[SW-1:0];
                    end else begin
                        n_event = EV_NAK;
                        n_error = ERR_NO_EOT;
                    end
                end
                default: begin
                    if (i_rx_byte == CH_SOH) begin
                        n_count = '0;
                    end else if (r_passthrough) begin
                        n_event = EV_PASS;
                        n_data  = i_rx_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passthrough <= 1'b0;
            r_state       <= ST_IDLE;
            r_xor         <= 8'd0;
            r_count       <= '0;
            r_ack         <= 8'd0;
            r_src         <= 8'd0;
            r_dst         <= 8'd0;
            r_sysid       <= 8'd0;
            r_type        <= 8'd0;
            r_serial      <= 16'd0;
            r_size        <= 16'd0;
            r_slot_idx    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_passthrough <= i_cfg_wr_data;
            end
            if (accept) begin
                r_state     <= n_state;
                r_xor       <= n_xor;
                r_count     <= n_count;
                r_ack       <= n_ack;
                r_src       <= n_src;
                r_dst       <= n_dst;
                r_sysid     <= n_sysid;
                r_type      <= n_type;
                r_serial    <= n_serial;
                r_size      <= n_size;
                r_slot_idx  <= n_slot_idx;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; header outputs come straight from the header registers,
    // which only change when the next request replaces this result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event    <= n_event;
            r_error    <= n_error;
            r_data     <= n_data;
            r_index    <= n_index;
            r_slot_out <= slot_ext[2:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_res     = r_event;
    assign o_data_byte     = r_data;
    assign o_byte_index    = r_index;
    assign o_expect_ack    = r_ack;
    assign o_src_addr      = r_src;
    assign o_dst_addr      = r_dst;
    assign o_system_id     = r_sysid;
    assign o_msg_type      = r_type;
    assign o_serial_number = r_serial;
    assign o_msg_size      = r_size;
    assign o_error_code    = r_error;
    assign o_slot          = r_slot_out;

endmodule
